>>> rtl/core/complex_fir_filter_macros.svh
// Assertion macros for the complex FIR filter.
// CFIR_ASSERT checks a property outside reset; CFIR_ASSERT_RST checks it on
// every edge, reset included. Both sample on clk; only CFIR_ASSERT uses rst.
`ifndef COMPLEX_FIR_FILTER_MACROS_SVH
`define COMPLEX_FIR_FILTER_MACROS_SVH

`ifndef SYNTHESIS
`define CFIR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define CFIR_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define CFIR_ASSERT(name, prop, msg)
`define CFIR_ASSERT_RST(name, prop, msg)
`endif

`endif

>>> rtl/core/cfir_pkg.sv
package cfir_pkg;

  localparam int TAP_COUNT_W  = 7;
  localparam int COEF_INDEX_W = 6;
  // Coefficient slots reachable through coef_index.
  localparam int COEF_SLOTS   = 64;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_COEF   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_RESULT
  } cfir_state_t;

  typedef struct packed {
    logic sample_we;
    logic coef_we;
    logic acc_clr;
    logic issue;
    logic res_load;
  } cfir_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic out_full;
  } cfir_status_t;

endpackage

>>> rtl/core/cfir_ctrl.sv
module cfir_ctrl #(
  parameter int MAX_TAPS = 64,
  parameter int AW       = 6
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              op,
  input  logic                              cfg_we,
  input  logic [cfir_pkg::TAP_COUNT_W-1:0]  cfg_data,
  input  cfir_pkg::cfir_status_t            st,
  output cfir_pkg::cfir_cmd_t               cmd,
  output logic [AW-1:0]                     tap_idx
);
  import cfir_pkg::*;

  localparam int DEPTH     = (MAX_TAPS < COEF_SLOTS) ? MAX_TAPS : COEF_SLOTS;
  localparam int TAP_RESET = (MAX_TAPS > 127) ? 127 : MAX_TAPS;

  cfir_state_t state, state_next;
  logic [TAP_COUNT_W-1:0] tap_count;
  logic [TAP_COUNT_W-1:0] taps_eff;
  logic [AW-1:0]          tap, tap_next;

  // Taps beyond the coefficient slots multiply by zero, so stop there.
  always_comb begin
    taps_eff = tap_count;
    if (tap_count == '0) begin
      taps_eff = TAP_COUNT_W'(1);
    end else if (tap_count > TAP_COUNT_W'(DEPTH)) begin
      taps_eff = TAP_COUNT_W'(DEPTH);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      tap_count <= TAP_COUNT_W'(TAP_RESET);
      tap       <= '0;
    end else begin
      state <= state_next;
      tap   <= tap_next;
      if (cfg_we) begin
        tap_count <= cfg_data;
      end
    end
  end

  assign tap_idx = tap;

  always_comb begin
    state_next   = state;
    tap_next     = tap;
    in_ready     = 1'b0;
    cmd          = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.coef_we   = (op == OP_COEF);
          cmd.sample_we = (op == OP_SAMPLE);
          cmd.acc_clr   = (op == OP_SAMPLE);
          tap_next      = '0;
          if (op == OP_SAMPLE) begin
            state_next = ST_ISSUE;
          end
        end
      end
      ST_ISSUE: begin
        cmd.issue = 1'b1;
        if (TAP_COUNT_W'(tap) == taps_eff - TAP_COUNT_W'(1)) begin
          state_next = ST_DRAIN;
        end else begin
          tap_next = tap + AW'(1);
        end
      end
      ST_DRAIN: begin
        if (!st.pipe_busy) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!st.out_full) begin
          cmd.res_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

>>> rtl/core/cfir_datapath.sv
module cfir_datapath #(
  parameter int MAX_TAPS     = 64,
  parameter int SAMPLE_WIDTH = 16,
  parameter int AW           = 6
) (
  input  logic                               clk,
  input  logic                               rst,
  input  cfir_pkg::cfir_cmd_t                cmd,
  input  logic [AW-1:0]                      tap_idx,
  input  logic signed [SAMPLE_WIDTH-1:0]     sample_re,
  input  logic signed [SAMPLE_WIDTH-1:0]     sample_im,
  input  logic                               in_last,
  input  logic [cfir_pkg::COEF_INDEX_W-1:0]  coef_index,
  input  logic signed [SAMPLE_WIDTH-1:0]     coef_re,
  input  logic signed [SAMPLE_WIDTH-1:0]     coef_im,
  output cfir_pkg::cfir_status_t             st,
  output logic signed [SAMPLE_WIDTH-1:0]     out_re,
  output logic signed [SAMPLE_WIDTH-1:0]     out_im,
  output logic                               out_last,
  output logic                               saturated,
  output logic                               out_valid,
  input  logic                               out_ready
);
  import cfir_pkg::*;

  localparam int SW    = SAMPLE_WIDTH;
  localparam int DEPTH = (MAX_TAPS < COEF_SLOTS) ? MAX_TAPS : COEF_SLOTS;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int ACC_W = 2 * SW + $clog2(DEPTH) + 2;

  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (SW - 2);
  localparam logic signed [ACC_W-1:0] HI   = (ACC_W'(1) << (SW - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] LO   = ~HI;
  localparam logic [COEF_INDEX_W:0]   DEPTH_IDX = (COEF_INDEX_W + 1)'(DEPTH);

  // Round half up, drop SW-1 fraction bits, clip; returns {clip, value}.
  function automatic logic [SW:0] round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] t;
    logic signed [ACC_W-1:0] q;
    t = acc + HALF;
    q = t >>> (SW - 1);
    if (q > HI) begin
      round_sat = {1'b1, HI[SW-1:0]};
    end else if (q < LO) begin
      round_sat = {1'b1, LO[SW-1:0]};
    end else begin
      round_sat = {1'b0, q[SW-1:0]};
    end
  endfunction

  logic [2*SW-1:0] dmem [DEPTH];
  logic [2*SW-1:0] cmem [DEPTH];
  logic [DEPTH-1:0] coef_vld;

  logic [AW-1:0]   newest, newest_inc, rd_addr;
  logic [CW-1:0]   fill;
  logic            last_q;
  logic            coef_hit;

  logic            s1_vld, s2_vld;
  logic [2*SW-1:0] d_q, c_q;
  logic            d_ok, c_ok;
  logic signed [SW-1:0]   ar, ai, cr, ci;
  logic signed [2*SW-1:0] p_rr, p_ii, p_ri, p_ir;
  logic signed [ACC_W-1:0] acc_re, acc_im;
  logic [SW:0]     res_re, res_im;

  assign newest_inc = (newest == AW'(DEPTH - 1)) ? '0 : newest + AW'(1);
  // Step back tap_idx entries from the newest, wrapping at DEPTH.
  assign rd_addr    = (newest >= tap_idx) ? newest - tap_idx :
                      AW'({1'b0, newest} + (AW + 1)'(DEPTH) - {1'b0, tap_idx});
  assign coef_hit   = ({1'b0, coef_index} < DEPTH_IDX);

  // Memories: one write and one registered read per cycle each.
  always_ff @(posedge clk) begin
    if (cmd.sample_we) begin
      dmem[newest_inc] <= {sample_re, sample_im};
    end
    if (cmd.coef_we && coef_hit) begin
      cmem[coef_index[AW-1:0]] <= {coef_re, coef_im};
    end
    d_q <= dmem[rd_addr];
    c_q <= cmem[tap_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      newest    <= AW'(DEPTH - 1);
      fill      <= '0;
      coef_vld  <= '0;
      s1_vld    <= 1'b0;
      s2_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_vld <= cmd.issue;
      s2_vld <= s1_vld;
      if (cmd.sample_we) begin
        newest <= newest_inc;
        if (fill != CW'(DEPTH)) begin
          fill <= fill + CW'(1);
        end
      end
      if (cmd.coef_we && coef_hit) begin
        coef_vld[coef_index[AW-1:0]] <= 1'b1;
      end
      if (cmd.res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Entries never filled or coefficients never written read as zero.
  assign ar = d_ok ? signed'(d_q[2*SW-1:SW]) : '0;
  assign ai = d_ok ? signed'(d_q[SW-1:0])    : '0;
  assign cr = c_ok ? signed'(c_q[2*SW-1:SW]) : '0;
  assign ci = c_ok ? signed'(c_q[SW-1:0])    : '0;

  always_ff @(posedge clk) begin
    if (cmd.sample_we) begin
      last_q <= in_last;
    end
    if (cmd.issue) begin
      d_ok <= (CW'(tap_idx) < fill);
      c_ok <= coef_vld[tap_idx];
    end
    p_rr <= ar * cr;
    p_ii <= ai * ci;
    p_ri <= ar * ci;
    p_ir <= ai * cr;
    if (cmd.acc_clr) begin
      acc_re <= '0;
      acc_im <= '0;
    end else if (s2_vld) begin
      acc_re <= acc_re + ACC_W'(p_rr) - ACC_W'(p_ii);
      acc_im <= acc_im + ACC_W'(p_ri) + ACC_W'(p_ir);
    end
    if (cmd.res_load) begin
      out_re    <= signed'(res_re[SW-1:0]);
      out_im    <= signed'(res_im[SW-1:0]);
      saturated <= res_re[SW] | res_im[SW];
      out_last  <= last_q;
    end
  end

  assign res_re = round_sat(acc_re);
  assign res_im = round_sat(acc_im);

  assign st.pipe_busy = s1_vld | s2_vld;
  assign st.out_full  = out_valid & ~out_ready;

endmodule

>>> rtl/core/complex_fir_filter.sv
// Streaming complex FIR filter, direct form, with one shared complex MAC.
// An item with op = 0 shifts a complex Q1.15 sample into the delay line and
// yields one result: the complex sum over the first tap_count taps of sample
// times coefficient (tap 0 holds the newest sample), rounded half up, shifted
// right by SAMPLE_WIDTH-1 and clipped to SAMPLE_WIDTH bits; saturated flags a
// clip of either part and out_last copies in_last. An item with op = 1 writes
// one coefficient at coef_index (ignored at or beyond MAX_TAPS) and yields no
// result. A sample item occupies the block: one tap is read per cycle from
// the delay-line and coefficient memories into the shared multiply-accumulate
// pipeline, which then drains before rounding. A coefficient write leaves
// the block idle. tap_count of 0 acts as 1, and values above min(MAX_TAPS,
// COEF_SLOTS) act as that bound. After reset the delay line and coefficients
// read as zero at once. The result sits in an output register, so the next
// item is taken while it waits; tap_count may change only while idle.
`include "complex_fir_filter_macros.svh"

module complex_fir_filter #(
  parameter int MAX_TAPS     = 64,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  // input item channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               op,
  input  logic signed [SAMPLE_WIDTH-1:0]     sample_re,
  input  logic signed [SAMPLE_WIDTH-1:0]     sample_im,
  input  logic                               in_last,
  input  logic [cfir_pkg::COEF_INDEX_W-1:0]  coef_index,
  input  logic signed [SAMPLE_WIDTH-1:0]     coef_re,
  input  logic signed [SAMPLE_WIDTH-1:0]     coef_im,
  // result item channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]     out_re,
  output logic signed [SAMPLE_WIDTH-1:0]     out_im,
  output logic                               out_last,
  output logic                               saturated,
  // tap_count register
  input  logic                               cfg_we,
  input  logic [cfir_pkg::TAP_COUNT_W-1:0]   cfg_data
);
  import cfir_pkg::*;

  // Taps past the coefficient slots always multiply by zero: size for fewer.
  localparam int DEPTH = (MAX_TAPS < COEF_SLOTS) ? MAX_TAPS : COEF_SLOTS;
  localparam int AW    = $clog2(DEPTH);

  cfir_cmd_t    cmd;
  cfir_status_t st;
  logic [AW-1:0] tap_idx;

  // Sequencer: accept items, walk the taps, hand the result to the output.
  cfir_ctrl #(
    .MAX_TAPS (MAX_TAPS),
    .AW       (AW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .op       (op),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .st       (st),
    .cmd      (cmd),
    .tap_idx  (tap_idx)
  );

  // Memories, MAC pipeline, rounding and the output register.
  cfir_datapath #(
    .MAX_TAPS     (MAX_TAPS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .AW           (AW)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .tap_idx    (tap_idx),
    .sample_re  (sample_re),
    .sample_im  (sample_im),
    .in_last    (in_last),
    .coef_index (coef_index),
    .coef_re    (coef_re),
    .coef_im    (coef_im),
    .st         (st),
    .out_re     (out_re),
    .out_im     (out_im),
    .out_last   (out_last),
    .saturated  (saturated),
    .out_valid  (out_valid),
    .out_ready  (out_ready)
  );

  // Block comes out of reset ready for an item.
  `CFIR_ASSERT_RST(a_ready_after_rst, rst |=> in_ready, "not ready after reset")
  // Never take a new item while taps are still in the MAC pipeline.
  `CFIR_ASSERT(a_no_accept_busy, !(in_ready && st.pipe_busy), "ready while pipe busy")
  // Never overwrite a result that has not been taken.
  `CFIR_ASSERT(a_load_free, cmd.res_load |-> !(out_valid && !out_ready),
    "result overwritten")
  // A new result appears only from a result load.
  `CFIR_ASSERT(a_valid_src, $rose(out_valid) |-> $past(cmd.res_load),
    "out_valid without load")

endmodule
